>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define PIP_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |-> (CON)) \
    else $error("pip check failed: same-cycle rule");

// Next-cycle implication, masked while reset is asserted.
`define PIP_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON) \
  LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |=> (CON)) \
    else $error("pip check failed: next-cycle rule");

// Next-cycle implication that also holds through reset.
`define PIP_ASSERT_NXT_RST(LBL, CLK, ANT, CON) \
  LBL: assert property (@(posedge CLK) (ANT) |=> (CON)) \
    else $error("pip check failed: reset rule");

`endif

>>> rtl/core/pip_pkg.sv
package pip_pkg;

  // command codes carried in in_tuser
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } pip_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } pip_state_t;

  // command control travelling from the front queue to the engine
  typedef struct packed {
    pip_mode_t mode;
    logic      last;
  } pip_cmd_t;

  // result flags, inside_res in the lowest bit
  typedef struct packed {
    logic overflowed;
    logic near_vertex;
    logic inside_res;
  } pip_res_t;

  localparam int THR_W = 48;
  localparam logic [THR_W-1:0] THR_RESET = 48'd1717987;

  // differences of 2^25 or more are never near
  localparam int MAG_W   = 25;
  localparam int MAG_LIM = 2 ** MAG_W;
  localparam int SQ_W    = 2 * MAG_W;

  localparam int OUT_TDATA_W = 8;

  // command queue between front and engine
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

endpackage

>>> rtl/core/pip_front.sv
module pip_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         in_last,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output pip_pkg::pip_cmd_t            cmd,
  output logic signed [COORD_BITS-1:0] cmd_x,
  output logic signed [COORD_BITS-1:0] cmd_y
);
  import pip_pkg::*;

  localparam int EW = 2 * COORD_BITS + 3;

  logic [EW-1:0]  q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;
  logic           is_cmd;
  logic           push;
  logic           pop;
  logic [EW-1:0]  head;

  // classify: the unused code is taken and dropped
  always_comb begin
    unique case (pip_mode_t'(in_mode)) inside
      MODE_CLEAR, MODE_APPEND, MODE_QUERY: is_cmd = 1'b1;
      default:                             is_cmd = 1'b0;
    endcase
  end

  assign in_ready  = (fill_r != QCW'(QDEPTH));
  assign cmd_valid = (fill_r != '0);
  assign push      = in_valid && in_ready && is_cmd;
  assign pop       = cmd_valid && cmd_ready;

  // queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= {in_last, in_y, in_x, in_mode};
    end
  end

  assign head     = q_mem[rd_ptr_r];
  assign cmd.mode = pip_mode_t'(head[1:0]);
  assign cmd.last = head[EW-1];
  assign cmd_x    = signed'(head[COORD_BITS+1:2]);
  assign cmd_y    = signed'(head[2*COORD_BITS+1:COORD_BITS+2]);

endmodule

>>> rtl/core/pip_back.sv
module pip_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [pip_pkg::THR_W-1:0]    cfg_wdata,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pip_pkg::pip_cmd_t            cmd,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pip_pkg::pip_res_t            res
);
  import pip_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int AB = (DW > MAG_W + 1) ? DW : MAG_W + 1;
  localparam int EW = 2 * COORD_BITS + 1;

  // vertex store: {loop end, y, x}
  logic [EW-1:0] mem [MAX_VERTICES];

  pip_state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [THR_W-1:0] thr_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic             load_pt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             issue_r, issue_nxt;
  logic             rd_en;
  logic             mem_we;
  logic             flush;
  logic [CW-1:0]    last_idx;

  // stage 1: read data
  logic             s1_v_r;
  logic [CW-1:0]    s1_idx_r;
  logic [EW-1:0]    rd_data_r;
  logic signed [COORD_BITS-1:0] s1_x, s1_y, start_y_eff;
  logic             s1_last, s1_first, s1_end;
  logic signed [AB-1:0] dx, dy;
  logic [AB-1:0]    ax, ay;
  logic             cross_in, cross_close;

  // previous vertex and loop start
  logic signed [COORD_BITS-1:0] prv_x_r, prv_y_r, start_y_r;
  logic             prv_last_r;

  // stage 2: magnitudes and crossing toggle
  logic             s2_v_r;
  logic [MAG_W-1:0] s2_ax_r, s2_ay_r;
  logic             s2_far_r, s2_tog_r, s2_end_r, s2_fin_r;

  // stage 3: squares
  logic             s3_v_r;
  logic [SQ_W-1:0]  s3_sqx_r, s3_sqy_r;
  logic             s3_far_r, s3_tog_r, s3_end_r, s3_fin_r;

  // decision
  logic [SQ_W:0]    sq_total;
  logic             is_near, par_upd, rej;
  logic             par_r, par_nxt;
  logic             outer_r, outer_nxt;
  pip_res_t         rslt_r, rslt_nxt;
  pip_res_t         res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  assign last_idx = count_r - CW'(1);

  // stage 1 decode and geometry
  assign s1_x     = signed'(rd_data_r[COORD_BITS-1:0]);
  assign s1_y     = signed'(rd_data_r[2*COORD_BITS-1:COORD_BITS]);
  assign s1_last  = rd_data_r[EW-1];
  assign s1_first = (s1_idx_r == '0) || prv_last_r;
  assign s1_end   = s1_last || (s1_idx_r == last_idx);
  assign start_y_eff = s1_first ? s1_y : start_y_r;

  assign dx = AB'(px_r) - AB'(s1_x);
  assign dy = AB'(py_r) - AB'(s1_y);
  assign ax = dx[AB-1] ? AB'(-dx) : AB'(dx);
  assign ay = dy[AB-1] ? AB'(-dy) : AB'(dy);

  // edge from the previous vertex to this one, then the closing edge
  assign cross_in = !s1_first && (prv_x_r > px_r) &&
                    ((prv_y_r < py_r && s1_y > py_r) || (prv_y_r > py_r && s1_y < py_r));
  assign cross_close = s1_end && (s1_x > px_r) &&
                       ((s1_y < py_r && start_y_eff > py_r) ||
                        (s1_y > py_r && start_y_eff < py_r));

  // distance compare and loop parity
  assign sq_total = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};
  assign is_near  = !s3_far_r && (sq_total < (SQ_W + 1)'(thr_r));
  assign par_upd  = par_r ^ s3_tog_r;
  assign rej      = outer_r ? !par_upd : par_upd;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    rd_idx_nxt    = rd_idx_r;
    issue_nxt     = issue_r;
    par_nxt       = par_r;
    outer_nxt     = outer_r;
    rslt_nxt      = rslt_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    load_pt       = 1'b0;
    flush         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.mode)
            MODE_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            MODE_APPEND: begin
              if (count_r != CW'(MAX_VERTICES)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            MODE_QUERY: begin
              load_pt    = 1'b1;
              par_nxt    = 1'b0;
              outer_nxt  = 1'b1;
              rd_idx_nxt = '0;
              if (count_r == '0) begin
                rslt_nxt  = '{overflowed: ovf_r, near_vertex: 1'b0, inside_res: 1'b0};
                state_nxt = ST_DONE;
              end else begin
                issue_nxt = 1'b1;
                state_nxt = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        rd_en = issue_r;
        if (issue_r) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
          if (rd_idx_r == last_idx) begin
            issue_nxt = 1'b0;
          end
        end
        if (s3_v_r) begin
          if (is_near) begin
            rslt_nxt = '{overflowed: ovf_r, near_vertex: 1'b1, inside_res: 1'b0};
            flush    = 1'b1;
          end else begin
            par_nxt = par_upd;
            if (s3_end_r) begin
              if (rej) begin
                rslt_nxt = '{overflowed: ovf_r, near_vertex: 1'b0, inside_res: 1'b0};
                flush    = 1'b1;
              end else if (s3_fin_r) begin
                rslt_nxt = '{overflowed: ovf_r, near_vertex: 1'b0, inside_res: 1'b1};
                flush    = 1'b1;
              end else begin
                par_nxt   = 1'b0;
                outer_nxt = 1'b0;
              end
            end
          end
        end
        if (flush) begin
          issue_nxt = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_r || res_ready) begin
          res_nxt       = rslt_r;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= THR_RESET;
      issue_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      issue_r     <= issue_nxt;
      s1_v_r      <= rd_en && !flush;
      s2_v_r      <= s1_v_r && !flush;
      s3_v_r      <= s2_v_r && !flush;
      res_valid_r <= res_valid_nxt;
    end
  end

  // vertex store ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= {cmd.last, cmd_y, cmd_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[AW-1:0]];
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (load_pt) begin
      px_r <= cmd_x;
      py_r <= cmd_y;
    end
    rd_idx_r <= rd_idx_nxt;
    s1_idx_r <= rd_idx_r;
    par_r    <= par_nxt;
    outer_r  <= outer_nxt;
    rslt_r   <= rslt_nxt;
    res_r    <= res_nxt;
    if (s1_v_r) begin
      prv_x_r    <= s1_x;
      prv_y_r    <= s1_y;
      prv_last_r <= s1_last;
      start_y_r  <= start_y_eff;
    end
    s2_ax_r  <= ax[MAG_W-1:0];
    s2_ay_r  <= ay[MAG_W-1:0];
    s2_far_r <= (ax >= AB'(MAG_LIM)) || (ay >= AB'(MAG_LIM));
    s2_tog_r <= cross_in ^ cross_close;
    s2_end_r <= s1_end;
    s2_fin_r <= (s1_idx_r == last_idx);
    s3_sqx_r <= s2_ax_r * s2_ax_r;
    s3_sqy_r <= s2_ay_r * s2_ay_r;
    s3_far_r <= s2_far_r;
    s3_tog_r <= s2_tog_r;
    s3_end_r <= s2_end_r;
    s3_fin_r <= s2_fin_r;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> rtl/core/point_in_polygon_with_holes.sv
// Point-in-polygon test over stored vertex loops; the first loop is the outer
// boundary, later loops are holes.
// Input channel in_*: in_tuser is the command (0 clear, 1 append, 2 query),
// in_tdata holds coord_x then coord_y (signed Q8.16), in_tlast marks the last
// vertex of a loop on append. Code 3 is taken and dropped.
// Result channel out_*: one beat per query, nothing for clear or append.
// cfg_we/cfg_wdata load the squared near-distance threshold (Q.32).
// Beats enter a four-deep command queue, so the sender keeps going while the
// engine works. The engine does clear and append in its idle state. A query
// reads the vertex store through its single read port, one vertex a cycle,
// and passes each vertex through the read register and the stage 2 and
// stage 3 registers to the decision; an early rejection cuts the walk short.
// No new command is taken until the result has moved to the output register.
// A finished result sits in an output register; if the receiver stalls, the
// engine holds the next result and stops taking commands until it drains.
// Reset empties the store, clears the overflow flag and restores the default
// threshold; vertex contents themselves are not cleared.
module point_in_polygon_with_holes #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24,
  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pip_pkg::THR_W-1:0]       cfg_wdata,     // near_dist_sq
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,      // coord_x, coord_y
  input  logic [1:0]                      in_tuser,      // mode
  input  logic                            in_tlast,      // closes_loop
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata      // inside_res, near_vertex, overflowed
);
  import pip_pkg::*;

  logic                         cmd_valid;
  logic                         cmd_ready;
  pip_cmd_t                     cmd;
  logic signed [COORD_BITS-1:0] cmd_x, cmd_y;
  pip_res_t                     res;

  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_x      (signed'(in_tdata[COORD_BITS-1:0])),
    .in_y      (signed'(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_last   (in_tlast),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y)
  );

  pip_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_x     (cmd_x),
    .cmd_y     (cmd_y),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(OUT_TDATA_W - 3){1'b0}}, res};

endmodule

>>> rtl/core/pip_checker.sv
`include "assert_macros.svh"

module pip_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pip_pkg::*;

  // a stalled result beat stays offered
  `PIP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // no result beat right after reset
  `PIP_ASSERT_NXT_RST(a_out_reset, clk, !rst_n, !out_tvalid)

  // a point rejected as near is never reported inside
  `PIP_ASSERT_IMP(a_near_excl, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[1]))

  // padding bits of a result beat stay zero
  `PIP_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:3] == '0)

endmodule

bind point_in_polygon_with_holes pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
